FILE: src/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, register indexes and the BCD split for the clock/stopwatch/
// countdown timer.
// ----------------------------------------------------------------------------
package cst_pkg;

  typedef enum logic [1:0] {
    MODE_CLOCK = 2'd0,
    MODE_SW    = 2'd1,
    MODE_CD    = 2'd2
  } mode_t;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_ADDR_W-1:0] REG_PRESET_HOURS   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PRESET_MINUTES = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PRESET_SECONDS = 2'd2;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [6:0] HOURS_SW_MAX = 7'd99;
  localparam logic [4:0] HOURS_CLK_MAX = 5'd23;
  localparam logic [5:0] MIN_SEC_MAX  = 6'd59;

  typedef struct packed {
    logic tick;
    logic btn_clock;
    logic btn_stopwatch;
    logic btn_timer;
  } item_t;

  typedef struct packed {
    logic [3:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
    mode_t      shown_mode;
  } result_t;

  // Split 0..99 into tens and ones: multiply by 205/2048 for the tens.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(v) * 15'd205;
    q    = prod[14:11];
    r    = v - 7'(7'(q) * 7'd10);
    return {q, r[3:0]};
  endfunction

endpackage

FILE: src/cst_core.sv
// ----------------------------------------------------------------------------
// cst_core
// Time-keeping state, preset registers and the single-pass update that turns
// one item into the next state and the shown digits.
// ----------------------------------------------------------------------------
module cst_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cst_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cst_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           step_i,
  input  cst_pkg::item_t                 item_i,
  output cst_pkg::result_t               res_o
);
  import cst_pkg::*;

  logic [6:0] preset_h_r;
  logic [5:0] preset_m_r;
  logic [5:0] preset_s_r;

  logic [4:0] clk_h_r, clk_h_nxt;
  logic [5:0] clk_m_r, clk_m_nxt;
  logic [5:0] clk_s_r, clk_s_nxt;
  logic [6:0] sw_h_r, sw_h_nxt;
  logic [5:0] sw_m_r, sw_m_nxt;
  logic [5:0] sw_s_r, sw_s_nxt;
  logic [6:0] cd_h_r, cd_h_nxt;
  logic [5:0] cd_m_r, cd_m_nxt;
  logic [5:0] cd_s_r, cd_s_nxt;
  mode_t      mode_r, mode_nxt;
  logic [2:0] held_r;

  logic [2:0] lv;
  logic [2:0] rise;
  logic       cd_zero;
  logic [6:0] show_h;
  logic [5:0] show_m;
  logic [5:0] show_s;
  logic [7:0] bcd_h;
  logic [7:0] bcd_m;
  logic [7:0] bcd_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_h_r <= 7'd0;
      preset_m_r <= 6'd0;
      preset_s_r <= 6'd30;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PRESET_HOURS:   preset_h_r <= cfg_wdata;
        REG_PRESET_MINUTES: preset_m_r <= cfg_wdata[5:0];
        REG_PRESET_SECONDS: preset_s_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  assign lv      = {item_i.btn_timer, item_i.btn_stopwatch, item_i.btn_clock};
  assign rise    = lv & ~held_r;
  assign cd_zero = (cd_h_r == 7'd0) && (cd_m_r == 6'd0) && (cd_s_r == 6'd0);

  always_comb begin
    clk_h_nxt = clk_h_r;
    clk_m_nxt = clk_m_r;
    clk_s_nxt = clk_s_r;
    sw_h_nxt  = sw_h_r;
    sw_m_nxt  = sw_m_r;
    sw_s_nxt  = sw_s_r;
    cd_h_nxt  = cd_h_r;
    cd_m_nxt  = cd_m_r;
    cd_s_nxt  = cd_s_r;
    mode_nxt  = mode_r;

    if (rise[0]) begin
      mode_nxt = MODE_CLOCK;
      sw_h_nxt = 7'd0;
      sw_m_nxt = 6'd0;
      sw_s_nxt = 6'd0;
      cd_h_nxt = (preset_h_r > HOURS_SW_MAX) ? HOURS_SW_MAX : preset_h_r;
      cd_m_nxt = (preset_m_r > MIN_SEC_MAX) ? MIN_SEC_MAX : preset_m_r;
      cd_s_nxt = (preset_s_r > MIN_SEC_MAX) ? MIN_SEC_MAX : preset_s_r;
    end
    if (rise[1]) mode_nxt = MODE_SW;
    if (rise[2]) mode_nxt = MODE_CD;

    if (item_i.tick) begin
      if (clk_s_r != MIN_SEC_MAX) begin
        clk_s_nxt = clk_s_r + 6'd1;
      end else begin
        clk_s_nxt = 6'd0;
        if (clk_m_r != MIN_SEC_MAX) begin
          clk_m_nxt = clk_m_r + 6'd1;
        end else begin
          clk_m_nxt = 6'd0;
          clk_h_nxt = (clk_h_r >= HOURS_CLK_MAX) ? 5'd0 : clk_h_r + 5'd1;
        end
      end

      case (mode_nxt)
        MODE_SW: begin
          if (sw_s_nxt != MIN_SEC_MAX) begin
            sw_s_nxt = sw_s_nxt + 6'd1;
          end else begin
            sw_s_nxt = 6'd0;
            if (sw_m_nxt != MIN_SEC_MAX) begin
              sw_m_nxt = sw_m_nxt + 6'd1;
            end else begin
              sw_m_nxt = 6'd0;
              sw_h_nxt = (sw_h_nxt >= HOURS_SW_MAX) ? 7'd0 : sw_h_nxt + 7'd1;
            end
          end
        end
        MODE_CD: begin
          if (cd_h_nxt != 7'd0 || cd_m_nxt != 6'd0 || cd_s_nxt != 6'd0) begin
            if (cd_s_nxt != 6'd0) begin
              cd_s_nxt = cd_s_nxt - 6'd1;
            end else begin
              cd_s_nxt = MIN_SEC_MAX;
              if (cd_m_nxt != 6'd0) begin
                cd_m_nxt = cd_m_nxt - 6'd1;
              end else begin
                cd_m_nxt = MIN_SEC_MAX;
                cd_h_nxt = cd_h_nxt - 7'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mode_nxt)
      MODE_SW: begin
        show_h = sw_h_nxt;
        show_m = sw_m_nxt;
        show_s = sw_s_nxt;
      end
      MODE_CD: begin
        show_h = cd_h_nxt;
        show_m = cd_m_nxt;
        show_s = cd_s_nxt;
      end
      default: begin
        show_h = 7'(clk_h_nxt);
        show_m = clk_m_nxt;
        show_s = clk_s_nxt;
      end
    endcase
  end

  assign bcd_h = to_bcd(show_h);
  assign bcd_m = to_bcd(7'(show_m));
  assign bcd_s = to_bcd(7'(show_s));

  assign res_o.hour_tens   = bcd_h[7:4];
  assign res_o.hour_ones   = bcd_h[3:0];
  assign res_o.minute_tens = bcd_m[6:4];
  assign res_o.minute_ones = bcd_m[3:0];
  assign res_o.second_tens = bcd_s[6:4];
  assign res_o.second_ones = bcd_s[3:0];
  assign res_o.shown_mode  = mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_h_r <= 5'd12;
      clk_m_r <= 6'd0;
      clk_s_r <= 6'd0;
      sw_h_r  <= 7'd0;
      sw_m_r  <= 6'd0;
      sw_s_r  <= 6'd0;
      cd_h_r  <= 7'd0;
      cd_m_r  <= 6'd0;
      cd_s_r  <= 6'd30;
      mode_r  <= MODE_CLOCK;
      held_r  <= 3'd0;
    end else if (step_i) begin
      clk_h_r <= clk_h_nxt;
      clk_m_r <= clk_m_nxt;
      clk_s_r <= clk_s_nxt;
      sw_h_r  <= sw_h_nxt;
      sw_m_r  <= sw_m_nxt;
      sw_s_r  <= sw_s_nxt;
      cd_h_r  <= cd_h_nxt;
      cd_m_r  <= cd_m_nxt;
      cd_s_r  <= cd_s_nxt;
      mode_r  <= mode_nxt;
      held_r  <= lv;
    end
  end

  a_clk_range: assert property (@(posedge clk) disable iff (!rst_n)
    clk_h_r <= HOURS_CLK_MAX && clk_m_r <= MIN_SEC_MAX && clk_s_r <= MIN_SEC_MAX)
    else $error("clock time out of range");

  a_cd_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && cd_zero && !rise[0] |=> cd_zero)
    else $error("countdown left zero without reload");

  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !step_i |=> $stable(clk_s_r) && $stable(mode_r) && $stable(held_r))
    else $error("state moved without a step");

  a_held_buttons: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && rise == 3'd0 |=> mode_r == $past(mode_r))
    else $error("mode changed without a button press");

endmodule

FILE: src/clock_stopwatch_timer_top.sv
// ----------------------------------------------------------------------------
// clock_stopwatch_timer_top
// 24-hour clock, stopwatch and countdown timer with a six-digit BCD result.
// ----------------------------------------------------------------------------
// Takes one transfer per clock cycle when the output side is not stalled and
// returns one result for each via the input and result registers. The input
// register feeds a single pass of update logic that writes the time-keeping
// state and the result register in the same cycle; a stall on the output holds
// both registers, and the input side keeps taking transfers while the input
// register is empty or moving.
module clock_stopwatch_timer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [0] tick, [1] btn_clock, [2] btn_stopwatch, [3] btn_timer, [7:4] zero
  input  logic [cst_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [3:0] hour_tens, [7:4] hour_ones, [10:8] minute_tens, [14:11] minute_ones,
  // [17:15] second_tens, [21:18] second_ones, [23:22] zero
  output logic [cst_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] shown_mode
  output logic [cst_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                           cfg_we,
  input  logic [cst_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cst_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cst_pkg::*;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    out_free;
  logic    step;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.tick          <= in_tdata[0];
      s1_item_r.btn_clock     <= in_tdata[1];
      s1_item_r.btn_stopwatch <= in_tdata[2];
      s1_item_r.btn_timer     <= in_tdata[3];
    end
    if (step) out_res_r <= res;
  end

  cst_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step_i    (step),
    .item_i    (s1_item_r),
    .res_o     (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.second_ones, out_res_r.second_tens,
                       out_res_r.minute_ones, out_res_r.minute_tens,
                       out_res_r.hour_ones, out_res_r.hour_tens};
  assign out_tuser  = out_res_r.shown_mode;

endmodule
